// ===== design/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, codes and helpers of the clock frame replacement unit.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Default number of frame cells
    localparam int NUM_FRAMES_DEF = 64;

    // Field widths
    localparam int CFG_W = 7;
    localparam int IDX_W = 6;

    typedef logic [CFG_W-1:0] t_pool;
    typedef logic [IDX_W-1:0] t_idx;

    // Command codes
    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_FREE   = 3'd1;
    localparam logic [2:0] CMD_ACCESS = 3'd2;
    localparam logic [2:0] CMD_PIN    = 3'd3;
    localparam logic [2:0] CMD_UNPIN  = 3'd4;

    // Page types
    localparam logic [1:0] PT_MMAP  = 2'd0;
    localparam logic [1:0] PT_FILE  = 2'd1;
    localparam logic [1:0] PT_STACK = 2'd2;

    // Victim write-back actions
    localparam logic [1:0] ACT_DISCARD = 2'd0;
    localparam logic [1:0] ACT_SWAP    = 2'd1;
    localparam logic [1:0] ACT_FILE    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_PINNED  = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic       exec;    // command cycle
        logic       sweep;   // hand sweep cycle
        logic       norm;    // pull an out-of-pool hand back to cell 0
        logic [2:0] cmd;
        t_idx       idx;
        logic       wr;
        logic [1:0] ptype;
        logic       pdirty;
        t_pool      pool;
    } t_bcast;

    // Status from one cell to the sequencer
    typedef struct packed {
        logic       free;      // in pool and not valid
        logic       unpinned;  // in pool and not pinned
        logic       bad;       // addressed, in pool, not valid
        logic       scan;      // holds the free-scan token
        logic       claim;     // free scan takes this cell now
        logic       evict;     // hand evicts this cell now
        logic [1:0] action;    // write-back of the victim
        logic       tok;       // holds the clock hand
        logic       stray;     // holds the hand outside the pool
        logic       tok_pass;  // hands the clock hand on this cycle
        logic       last;      // last cell of the pool
    } t_cell_stat;

    // One result word, first field in the high bits
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] action;
        logic       evicted;
        t_idx       granted;
    } t_result;

    // Write-back needed for an evicted page
    function automatic logic [1:0] action_of(logic [1:0] ptype, logic dirty);
        logic [1:0] act;
        case (ptype)
            PT_MMAP:  act = dirty ? ACT_FILE : ACT_DISCARD;
            PT_FILE:  act = dirty ? ACT_SWAP : ACT_DISCARD;
            PT_STACK: act = ACT_SWAP;
            default:  act = ACT_DISCARD;
        endcase
        return act;
    endfunction

endpackage

// ===== design/cfr_cell.sv =====
// ----------------------------------------------------------------------------
// cfr_cell
// One frame slot: entry bits, clock hand token and free-scan token.
// ----------------------------------------------------------------------------
module cfr_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cfr_pkg::t_bcast       i_bc,
    input  logic                  i_scan_in,
    input  logic                  i_tok_in,
    output logic                  o_scan_out,
    output cfr_pkg::t_cell_stat   o_stat
);

    // Entry and tokens
    logic       r_valid, r_pinned, r_acc, r_dirty;
    logic [1:0] r_type;
    logic       r_tok, r_scan;
    logic       n_valid, n_pinned, n_acc, n_dirty;
    logic [1:0] n_type;
    logic       n_tok;

    logic in_pool, last, match, addr;
    logic claim, step, evict, clr_acc, tok_pass, drop;

    always_comb begin
        in_pool  = CELL_ID < int'(i_bc.pool);
        last     = (CELL_ID + 1) == int'(i_bc.pool);
        match    = in_pool && (CELL_ID == int'(i_bc.idx));
        addr     = i_bc.exec && match && r_valid;
        claim    = r_scan && in_pool && !r_valid;
        step     = i_bc.sweep && r_tok;
        evict    = step && !r_pinned && !r_acc;
        clr_acc  = step && !r_pinned && r_acc;
        // hand moves on every sweep step, and off a freed slot
        tok_pass = step || (addr && r_tok && (i_bc.cmd == cfr_pkg::CMD_FREE));
        drop     = i_bc.norm && r_tok && !in_pool;
    end

    // Next entry value
    always_comb begin
        n_valid  = r_valid;
        n_pinned = r_pinned;
        n_acc    = r_acc;
        n_dirty  = r_dirty;
        n_type   = r_type;
        if (claim || evict) begin
            n_valid  = 1'b1;
            n_pinned = 1'b0;
            n_acc    = 1'b0;
            n_dirty  = i_bc.pdirty;
            n_type   = i_bc.ptype;
        end else if (clr_acc) begin
            n_acc = 1'b0;
        end else if (addr) begin
            case (i_bc.cmd)
                cfr_pkg::CMD_FREE: begin
                    n_valid  = 1'b0;
                    n_pinned = 1'b0;
                    n_acc    = 1'b0;
                    n_dirty  = 1'b0;
                    n_type   = cfr_pkg::PT_MMAP;
                end
                cfr_pkg::CMD_ACCESS: begin
                    n_acc   = 1'b1;
                    n_dirty = r_dirty | i_bc.wr;
                end
                cfr_pkg::CMD_PIN:   n_pinned = 1'b1;
                cfr_pkg::CMD_UNPIN: n_pinned = 1'b0;
                default: ;
            endcase
        end
        n_tok = (r_tok && !tok_pass && !drop) || i_tok_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_pinned <= 1'b0;
            r_acc    <= 1'b0;
            r_dirty  <= 1'b0;
            r_type   <= cfr_pkg::PT_MMAP;
            r_tok    <= (CELL_ID == 0);
            r_scan   <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_pinned <= n_pinned;
            r_acc    <= n_acc;
            r_dirty  <= n_dirty;
            r_type   <= n_type;
            r_tok    <= n_tok;
            r_scan   <= i_scan_in;
        end
    end

    // Scan token moves on until a free slot takes it
    assign o_scan_out = r_scan && !claim;

    always_comb begin
        o_stat.free     = in_pool && !r_valid;
        o_stat.unpinned = in_pool && !r_pinned;
        o_stat.bad      = match && !r_valid;
        o_stat.scan     = r_scan;
        o_stat.claim    = claim;
        o_stat.evict    = evict;
        o_stat.action   = evict ? cfr_pkg::action_of(r_type, r_dirty) : cfr_pkg::ACT_DISCARD;
        o_stat.tok      = r_tok;
        o_stat.stray    = r_tok && !in_pool;
        o_stat.tok_pass = tok_pass;
        o_stat.last     = last;
    end

endmodule

// ===== design/clock_frame_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// clock_frame_replacement_unit
// Frame table with clock (second-chance) replacement over a row of cells.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_axis    | in        | tdata: command[2:0] frame_index[8:3] is_write[9]
//            |           |        page_type[11:10] prior_dirty[12]
//  m_axis    | out       | tdata: granted_frame[5:0] evicted[6]
//            |           |        victim_action[8:7] status[10:9]
//  cfg       | in        | data: pool_frames[6:0]
//
//  Free, access, pin, unpin and unused commands pass through the exec and
//  done states. Allocate of a free slot takes the lowest free slot: the
//  free-scan token walks the cell row one cell per cycle. Allocate with a
//  full pool sweeps the clock hand, which steps one cell per cycle and may
//  pass the ring twice. All-pinned is seen at once.
//  Reset clears every cell at once; no clearing pass. One word in flight;
//  a finished word waits in the output register while the next is taken.
// ----------------------------------------------------------------------------
module clock_frame_replacement_unit #(
    parameter int NUM_FRAMES = cfr_pkg::NUM_FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [15:0]                s_axis_tdata,   // command, frame_index, is_write,
                                                       // page_type, prior_dirty
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // granted_frame, evicted,
                                                       // victim_action, status
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cfr_pkg::CFG_W-1:0]  i_cfg_data      // pool_frames
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    localparam cfr_pkg::t_pool POOL_RST =
        (NUM_FRAMES < 64) ? cfr_pkg::t_pool'(NUM_FRAMES) : cfr_pkg::t_pool'(64);

    t_state               r_state, n_state;
    cfr_pkg::t_pool       r_pool;
    logic [2:0]           r_cmd;
    cfr_pkg::t_idx        r_idx;
    logic                 r_wr, r_pdirty;
    logic [1:0]           r_ptype;
    cfr_pkg::t_result     r_res, n_res;
    cfr_pkg::t_result     r_out;
    logic                 r_out_valid;

    logic                 accept, load_out, scan_start, norm;
    cfr_pkg::t_bcast      bc;
    cfr_pkg::t_cell_stat  stat [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] scan_out, tok_in;
    logic [NUM_FRAMES-1:0] w_tok, w_pick, w_scan;

    logic                 any_free, any_unpinned, any_bad, any_claim, any_evict;
    logic                 any_stray, wrap;
    cfr_pkg::t_idx        pick_idx;
    logic [1:0]           act_or;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // Pool size register, clamped to 1..NUM_FRAMES on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                r_pool <= cfr_pkg::t_pool'(1);
            end else if (int'(i_cfg_data) > NUM_FRAMES) begin
                r_pool <= cfr_pkg::t_pool'(NUM_FRAMES);
            end else begin
                r_pool <= i_cfg_data;
            end
        end
    end

    // Command word capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= s_axis_tdata[2:0];
            r_idx    <= s_axis_tdata[8:3];
            r_wr     <= s_axis_tdata[9];
            r_ptype  <= s_axis_tdata[11:10];
            r_pdirty <= s_axis_tdata[12];
        end
    end

    // Broadcast to the cell row
    always_comb begin
        bc.exec   = (r_state == S_EXEC);
        bc.sweep  = (r_state == S_SWEEP);
        bc.norm   = norm;
        bc.cmd    = r_cmd;
        bc.idx    = r_idx;
        bc.wr     = r_wr;
        bc.ptype  = r_ptype;
        bc.pdirty = r_pdirty;
        bc.pool   = r_pool;
    end

    // Cell row; hand wraps from the pool's last cell back to cell 0
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign tok_in[g] = wrap || (norm && any_stray);
            cfr_cell #(.CELL_ID(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_bc       (bc),
                .i_scan_in  (scan_start),
                .i_tok_in   (tok_in[g]),
                .o_scan_out (scan_out[g]),
                .o_stat     (stat[g])
            );
        end else begin : g_body
            assign tok_in[g] = stat[g-1].tok_pass && !stat[g-1].last;
            cfr_cell #(.CELL_ID(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_bc       (bc),
                .i_scan_in  (scan_out[g-1]),
                .i_tok_in   (tok_in[g]),
                .o_scan_out (scan_out[g]),
                .o_stat     (stat[g])
            );
        end
        assign w_tok[g]  = stat[g].tok;
        assign w_pick[g] = stat[g].claim || stat[g].evict;
        assign w_scan[g] = stat[g].scan;
    end

    // Row-wide flags and selected slot
    always_comb begin
        any_free     = 1'b0;
        any_unpinned = 1'b0;
        any_bad      = 1'b0;
        any_claim    = 1'b0;
        any_evict    = 1'b0;
        any_stray    = 1'b0;
        wrap         = 1'b0;
        pick_idx     = '0;
        act_or       = cfr_pkg::ACT_DISCARD;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            any_free     = any_free     | stat[i].free;
            any_unpinned = any_unpinned | stat[i].unpinned;
            any_bad      = any_bad      | stat[i].bad;
            any_claim    = any_claim    | stat[i].claim;
            any_evict    = any_evict    | stat[i].evict;
            any_stray    = any_stray    | stat[i].stray;
            wrap         = wrap | (stat[i].tok_pass & stat[i].last);
            pick_idx     = pick_idx | (w_pick[i] ? cfr_pkg::t_idx'(i) : '0);
            act_or       = act_or | stat[i].action;
        end
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        scan_start = 1'b0;
        norm       = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                if (r_cmd == cfr_pkg::CMD_ALLOC) begin
                    if (any_free) begin
                        scan_start = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        norm = 1'b1;
                        if (any_unpinned) begin
                            n_state = S_SWEEP;
                        end else begin
                            n_res.status = cfr_pkg::ST_PINNED;
                        end
                    end
                end else if (r_cmd <= cfr_pkg::CMD_UNPIN) begin
                    if ({1'b0, r_idx} >= r_pool) begin
                        n_res.status = cfr_pkg::ST_RANGE;
                    end else if (any_bad) begin
                        n_res.status = cfr_pkg::ST_INVALID;
                    end
                end
            end
            S_SCAN: begin
                if (any_claim) begin
                    n_res.granted = pick_idx;
                    n_state       = S_DONE;
                end
            end
            S_SWEEP: begin
                if (any_evict) begin
                    n_res.granted = pick_idx;
                    n_res.evicted = 1'b1;
                    n_res.action  = act_or;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) r_out <= r_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out};

`ifndef SYNTH
    // exactly one cell holds the clock hand
    a_one_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_tok))
        else $error("clock hand token lost or duplicated");

    // at most one slot is granted per cycle
    a_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_pick))
        else $error("more than one slot claimed or evicted");

    // the sweeping hand stays inside the pool
    a_hand_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !any_stray)
        else $error("hand outside pool during sweep");

    // the free scan never runs off the row
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> $onehot(w_scan))
        else $error("free scan token lost");
`endif

endmodule
